FILE: src/fsp_pkg.sv
// shared types, codes and constants for the serial flash program loader
// used by every module of the block; depends on nothing
package fsp_pkg;

   localparam int PAGE_BUFFER_BYTES_DEF = 512;
   localparam int ERASE_PAGE_BYTES_DEF  = 1024;
   localparam int WIDX_W                = 10;
   localparam int MAX_RESULTS           = 5;

   localparam logic [7:0] B_SYNC    = 8'h30;
   localparam logic [7:0] B_EOP     = 8'h20;
   localparam logic [7:0] B_INSYNC  = 8'h14;
   localparam logic [7:0] B_OK      = 8'h10;
   localparam logic [7:0] C_GETPARM = 8'h41;
   localparam logic [7:0] C_SETDEV  = 8'h42;
   localparam logic [7:0] C_SETDEVX = 8'h45;
   localparam logic [7:0] C_LEAVE   = 8'h51;
   localparam logic [7:0] C_LOADADR = 8'h55;
   localparam logic [7:0] C_UNIV    = 8'h56;
   localparam logic [7:0] C_PROG    = 8'h64;
   localparam logic [7:0] C_READ    = 8'h74;
   localparam logic [7:0] C_SIGN    = 8'h75;
   localparam logic [7:0] P_MINOR   = 8'h82;
   localparam logic [7:0] P_MAJOR   = 8'h81;
   localparam logic [7:0] VER_MAJOR = 8'd4;
   localparam logic [7:0] VER_MINOR = 8'd6;
   localparam logic [7:0] VER_OTHER = 8'h03;

   localparam logic [2:0] MC_NONE  = 3'd0;
   localparam logic [2:0] MC_READ  = 3'd1;
   localparam logic [2:0] MC_ERASE = 3'd2;
   localparam logic [2:0] MC_WRITE = 3'd3;
   localparam logic [2:0] MC_LEAVE = 3'd4;

   localparam logic [2:0] CSR_ENTRY_ON_SYNC = 3'd0;
   localparam logic [2:0] CSR_BOOT_AREA_END = 3'd1;
   localparam logic [2:0] CSR_FLASH_LIMIT   = 3'd2;
   localparam logic [2:0] CSR_SIG_HIGH      = 3'd3;
   localparam logic [2:0] CSR_SIG_MID       = 3'd4;
   localparam logic [2:0] CSR_SIG_LOW       = 3'd5;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic [2:0]  mem_cmd;
      logic [16:0] mem_addr;
      logic        abandon;
      logic        use_word;
   } ent_type;

   typedef struct packed {
      logic [2:0]              cnt;
      ent_type [4:0]           ent;
      logic [WIDX_W-1:0]       widx;
      logic [3:0]              mask;
      logic                    inv;
   } job_type;

   typedef struct packed {
      logic        entry_on_sync;
      logic [17:0] boot_area_end;
      logic [17:0] flash_limit;
      logic [7:0]  sig_high;
      logic [7:0]  sig_mid;
      logic [7:0]  sig_low;
   } cfg_type;

   typedef struct packed {
      logic              en;
      logic [WIDX_W-1:0] widx;
      logic [1:0]        lane;
      logic [7:0]        data;
   } buf_wr_type;

   function automatic logic [4:0] arg_total(logic [7:0] c);
      logic [4:0] n;
      case (c)
         C_GETPARM: n = 5'd1;
         C_SETDEV:  n = 5'd20;
         C_SETDEVX: n = 5'd5;
         C_LOADADR: n = 5'd2;
         C_UNIV:    n = 5'd4;
         C_PROG:    n = 5'd3;
         C_READ:    n = 5'd3;
         default:   n = 5'd0;
      endcase
      return n;
   endfunction

   function automatic ent_type mk_ent(logic txv, logic [7:0] txb, logic [2:0] cmd,
                                      logic [16:0] addr, logic ab, logic uw);
      ent_type e;
      e.tx_valid = txv;
      e.tx_byte  = txb;
      e.mem_cmd  = cmd;
      e.mem_addr = addr;
      e.abandon  = ab;
      e.use_word = uw;
      return e;
   endfunction

endpackage

FILE: src/serial_flash_program_loader.sv
// serial flash program loader top level: configuration registers and wiring
// depends on fsp_pkg, fsp_front, fsp_fifo and fsp_back
//
// usage
//   req channel: one item per received serial byte (req_op 0, req_rx_byte) or
//   per memory reply / write acknowledge (req_op 1, req_mem_data)
//   rsp channel: zero to five items per req item, the final one with rsp_last
//   csr channel: csr_index selects a register, csr_data its value; always ready;
//   the user must write it only while the block is idle, which is not enforced
// timing
//   a req item is taken every cycle while the two-entry job queue has room;
//   its rsp items pass through a queue slot and then the back end job register;
//   the front, a state machine, classifies each item; the back end reads the page
//   buffer memory once per job and sends one item per cycle while rsp_ready is
//   high; program data bytes wait while earlier jobs are still draining
// reset
//   synchronous reset returns to hunting for sync and loads register defaults
// stalls
//   a low rsp_ready holds the back end; the front keeps taking items until the
//   queue fills, then drops req_ready
module serial_flash_program_loader #(
   parameter int PAGE_BUFFER_BYTES = fsp_pkg::PAGE_BUFFER_BYTES_DEF,
   parameter int ERASE_PAGE_BYTES  = fsp_pkg::ERASE_PAGE_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [7:0]  req_rx_byte,
   input  logic [7:0]  req_mem_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic [2:0]  rsp_mem_cmd,
   output logic [16:0] rsp_mem_addr,
   output logic [31:0] rsp_mem_word,
   output logic        rsp_tx_inverted,
   output logic        rsp_abandon,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [17:0] csr_data
);

   fsp_pkg::cfg_type    cfg_ff, cfg_in;
   fsp_pkg::job_type    push_job;
   fsp_pkg::job_type    q_head;
   fsp_pkg::buf_wr_type buf_wr;
   logic                q_push;
   logic                q_pop;
   logic                q_nonempty;
   logic                q_full;
   logic                back_busy;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            fsp_pkg::CSR_ENTRY_ON_SYNC: cfg_in.entry_on_sync = csr_data[0];
            fsp_pkg::CSR_BOOT_AREA_END: cfg_in.boot_area_end = csr_data;
            fsp_pkg::CSR_FLASH_LIMIT:   cfg_in.flash_limit   = csr_data;
            fsp_pkg::CSR_SIG_HIGH:      cfg_in.sig_high      = csr_data[7:0];
            fsp_pkg::CSR_SIG_MID:       cfg_in.sig_mid       = csr_data[7:0];
            fsp_pkg::CSR_SIG_LOW:       cfg_in.sig_low       = csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.entry_on_sync <= 1'b1;
         cfg_ff.boot_area_end <= 18'd8192;
         cfg_ff.flash_limit   <= 18'd131072;
         cfg_ff.sig_high      <= 8'd30;
         cfg_ff.sig_mid       <= 8'd85;
         cfg_ff.sig_low       <= 8'd170;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fsp_front #(
      .PAGE_BUFFER_BYTES (PAGE_BUFFER_BYTES),
      .ERASE_PAGE_BYTES  (ERASE_PAGE_BYTES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_rx_byte  (req_rx_byte),
      .req_mem_data (req_mem_data),
      .q_full       (q_full),
      .back_busy    (back_busy),
      .q_push       (q_push),
      .q_job        (push_job),
      .buf_wr       (buf_wr)
   );

   fsp_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head     (q_head),
      .nonempty (q_nonempty),
      .full     (q_full)
   );

   fsp_back #(
      .PAGE_BUFFER_BYTES (PAGE_BUFFER_BYTES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .buf_wr          (buf_wr),
      .q_head          (q_head),
      .q_nonempty      (q_nonempty),
      .q_pop           (q_pop),
      .busy            (back_busy),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_tx_valid    (rsp_tx_valid),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_mem_cmd     (rsp_mem_cmd),
      .rsp_mem_addr    (rsp_mem_addr),
      .rsp_mem_word    (rsp_mem_word),
      .rsp_tx_inverted (rsp_tx_inverted),
      .rsp_abandon     (rsp_abandon),
      .rsp_last        (rsp_last)
   );

endmodule

FILE: src/fsp_fifo.sv
// two-entry job queue between the command front and the result back end
// depends on fsp_pkg for the job type
module fsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fsp_pkg::job_type  push_job,
   input  logic              pop,
   output fsp_pkg::job_type  head,
   output logic              nonempty,
   output logic              full
);

   fsp_pkg::job_type slot_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_in    = wr_ff ^ push;
      rd_in    = rd_ff ^ pop;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   assign head     = slot_ff[rd_ff];
   assign nonempty = (count_ff != 2'd0);
   assign full     = (count_ff == 2'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule

FILE: src/fsp_back.sv
// result back end: page buffer memory and expansion of queued jobs into items
// depends on fsp_pkg
module fsp_back #(
   parameter int PAGE_BUFFER_BYTES = fsp_pkg::PAGE_BUFFER_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  fsp_pkg::buf_wr_type buf_wr,
   input  fsp_pkg::job_type    q_head,
   input  logic                q_nonempty,
   output logic                q_pop,
   output logic                busy,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_tx_valid,
   output logic [7:0]          rsp_tx_byte,
   output logic [2:0]          rsp_mem_cmd,
   output logic [16:0]         rsp_mem_addr,
   output logic [31:0]         rsp_mem_word,
   output logic                rsp_tx_inverted,
   output logic                rsp_abandon,
   output logic                rsp_last
);

   localparam int DEPTH = PAGE_BUFFER_BYTES / 4;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [31:0] mem [DEPTH];

   fsp_pkg::job_type jb_ff;
   logic             jv_ff, jv_in;
   logic [2:0]       k_ff, k_in;
   logic [31:0]      word_ff;
   fsp_pkg::ent_type e;
   logic             fire;
   logic             is_last;

   always_comb begin
      e       = jb_ff.ent[k_ff];
      is_last = (k_ff == jb_ff.cnt - 3'd1);
      fire    = jv_ff && rsp_ready;
      q_pop   = q_nonempty && (!jv_ff || (fire && is_last));
      jv_in   = jv_ff;
      k_in    = k_ff;
      if (q_pop) begin
         jv_in = 1'b1;
         k_in  = 3'd0;
      end else if (fire) begin
         if (is_last) begin
            jv_in = 1'b0;
         end else begin
            k_in = k_ff + 3'd1;
         end
      end
      for (int i = 0; i < 4; i++) begin
         rsp_mem_word[8*i +: 8] = e.use_word ?
            (jb_ff.mask[i] ? word_ff[8*i +: 8] : 8'hFF) : 8'h00;
      end
   end

   assign busy            = jv_ff || q_nonempty;
   assign rsp_valid       = jv_ff;
   assign rsp_tx_valid    = e.tx_valid;
   assign rsp_tx_byte     = e.tx_byte;
   assign rsp_mem_cmd     = e.mem_cmd;
   assign rsp_mem_addr    = e.mem_addr;
   assign rsp_tx_inverted = jb_ff.inv;
   assign rsp_abandon     = e.abandon;
   assign rsp_last        = is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         jv_ff <= 1'b0;
         k_ff  <= 3'd0;
      end else begin
         jv_ff <= jv_in;
         k_ff  <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         jb_ff   <= q_head;
         word_ff <= mem[q_head.widx[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (buf_wr.en) begin
         mem[buf_wr.widx[AW-1:0]][{buf_wr.lane, 3'b000} +: 8] <= buf_wr.data;
      end
   end

endmodule

FILE: src/fsp_front.sv
// command front: protocol state machine that takes items and queues result jobs
// depends on fsp_pkg
module fsp_front #(
   parameter int PAGE_BUFFER_BYTES = fsp_pkg::PAGE_BUFFER_BYTES_DEF,
   parameter int ERASE_PAGE_BYTES  = fsp_pkg::ERASE_PAGE_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fsp_pkg::cfg_type     cfg,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_op,
   input  logic [7:0]           req_rx_byte,
   input  logic [7:0]           req_mem_data,
   input  logic                 q_full,
   input  logic                 back_busy,
   output logic                 q_push,
   output fsp_pkg::job_type     q_job,
   output fsp_pkg::buf_wr_type  buf_wr
);

   localparam int DEPTH = PAGE_BUFFER_BYTES / 4;
   localparam int CAP   = DEPTH * 4;
   localparam int WPW   = $clog2(DEPTH + 1);
   localparam int SH    = 17 + $clog2(ERASE_PAGE_BYTES);
   localparam longint RECIP = ((64'd1 << SH) + ERASE_PAGE_BYTES - 1) / ERASE_PAGE_BYTES;

   typedef enum logic [6:0] {
      PH_HUNT  = 7'b0000001,
      PH_CMD   = 7'b0000010,
      PH_ARGS  = 7'b0000100,
      PH_DATA  = 7'b0001000,
      PH_EOP   = 7'b0010000,
      PH_WRITE = 7'b0100000,
      PH_READ  = 7'b1000000
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [7:0]        prev_ff, prev_in;
   logic [7:0]        cmd_ff, cmd_in;
   logic [16:0]       off_ff, off_in;
   logic [15:0]       ac_ff, ac_in;
   logic [15:0]       tl_ff, tl_in;
   logic [7:0]        param_ff, param_in;
   logic              fail_ff, fail_in;
   logic [2:0]        sr_ff, sr_in;
   logic              inv_ff, inv_in;
   logic [WPW-1:0]    wp_ff, wp_in;
   logic [16:0]       quo_ff;
   logic              aligned_ff;

   logic              fire;
   logic [2:0]        cnt;
   logic [16:0]       len17;
   logic [16:0]       pb;
   logic [16:0]       words;
   logic [15:0]       idx;
   logic [15:0]       ac_dec;
   logic [15:0]       rd_idx;
   logic [2:0]        srn;
   logic [4:0]        tot;
   logic [47:0]       prod;
   logic [31:0]       back_prod;
   fsp_pkg::job_type  job;

   function automatic logic [3:0] word_mask(logic [WPW-1:0] w, logic [16:0] n);
      logic [3:0]  m;
      logic [17:0] base;
      base = {16'(w), 2'b00};
      for (int k = 0; k < 4; k++) begin
         m[k] = (base + 18'(k)) < {1'b0, n};
      end
      return m;
   endfunction

   assign req_ready = !q_full && !(phase_ff == PH_DATA && back_busy);
   assign fire      = req_valid && req_ready;

   always_comb begin
      prod      = 48'(off_ff) * 48'(RECIP);
      back_prod = 32'(quo_ff) * 32'(ERASE_PAGE_BYTES);
   end

   always_comb begin
      phase_in = phase_ff;
      prev_in  = prev_ff;
      cmd_in   = cmd_ff;
      off_in   = off_ff;
      ac_in    = ac_ff;
      tl_in    = tl_ff;
      param_in = param_ff;
      fail_in  = fail_ff;
      sr_in    = sr_ff;
      inv_in   = inv_ff;
      wp_in    = wp_ff;
      job      = '0;
      cnt      = 3'd0;
      buf_wr   = '0;
      len17    = (tl_ff == 16'd0) ? 17'h10000 : {1'b0, tl_ff};
      pb       = (len17 < 17'(CAP)) ? len17 : 17'(CAP);
      words    = (pb + 17'd3) >> 2;
      idx      = tl_ff - ac_ff;
      ac_dec   = ac_ff - 16'd1;
      rd_idx   = tl_ff - ac_dec;
      srn      = 3'd0;
      tot      = fsp_pkg::arg_total(cmd_ff);

      if (!req_op) begin
         case (phase_ff)
            PH_HUNT: begin
               if (prev_ff == fsp_pkg::B_SYNC && req_rx_byte != fsp_pkg::B_SYNC &&
                   req_rx_byte == fsp_pkg::B_EOP) begin
                  phase_in = PH_CMD;
               end else if (prev_ff == fsp_pkg::B_SYNC && req_rx_byte != fsp_pkg::B_SYNC &&
                            cfg.entry_on_sync) begin
                  job.ent[cnt] = fsp_pkg::mk_ent(1'b0, 8'h00, fsp_pkg::MC_NONE, 17'd0,
                                                 1'b1, 1'b0);
                  cnt          = cnt + 3'd1;
                  prev_in      = 8'h00;
                  sr_in        = 3'd0;
               end else begin
                  prev_in = req_rx_byte;
               end
            end
            PH_CMD: begin
               cmd_in = req_rx_byte;
               srn    = (req_rx_byte == fsp_pkg::B_SYNC) ? sr_ff + 3'd1 : 3'd0;
               if (srn > 3'd5) begin
                  inv_in = !inv_ff;
                  srn    = 3'd0;
               end
               sr_in    = srn;
               ac_in    = 16'd0;
               phase_in = (fsp_pkg::arg_total(req_rx_byte) != 5'd0) ? PH_ARGS : PH_EOP;
            end
            PH_ARGS: begin
               if (cmd_ff == fsp_pkg::C_GETPARM) begin
                  param_in = req_rx_byte;
               end else if (cmd_ff == fsp_pkg::C_LOADADR) begin
                  if (ac_ff == 16'd0) begin
                     param_in = req_rx_byte;
                  end else begin
                     off_in = {req_rx_byte, param_ff, 1'b0};
                  end
               end else if ((cmd_ff == fsp_pkg::C_PROG || cmd_ff == fsp_pkg::C_READ) &&
                            ac_ff < 16'd2) begin
                  tl_in = {tl_ff[7:0], req_rx_byte};
               end
               ac_in = ac_ff + 16'd1;
               if (ac_in >= 16'(tot)) begin
                  if (cmd_ff == fsp_pkg::C_PROG) begin
                     ac_in    = tl_in;
                     phase_in = PH_DATA;
                  end else begin
                     phase_in = PH_EOP;
                  end
               end
            end
            PH_DATA: begin
               if ({1'b0, idx} < 17'(CAP)) begin
                  buf_wr.en   = 1'b1;
                  buf_wr.widx = fsp_pkg::WIDX_W'(idx >> 2);
                  buf_wr.lane = idx[1:0];
                  buf_wr.data = req_rx_byte;
               end
               ac_in = ac_dec;
               if (ac_dec == 16'd0) begin
                  phase_in = PH_EOP;
               end
            end
            PH_EOP: begin
               fail_in = (req_rx_byte != fsp_pkg::B_EOP);
               if (!fail_in) begin
                  job.ent[cnt] = fsp_pkg::mk_ent(1'b1, fsp_pkg::B_INSYNC, fsp_pkg::MC_NONE,
                                                 17'd0, 1'b0, 1'b0);
                  cnt          = cnt + 3'd1;
               end
               phase_in = fail_in ? PH_HUNT : PH_CMD;
               case (cmd_ff)
                  fsp_pkg::C_GETPARM: begin
                     job.ent[cnt] = fsp_pkg::mk_ent(1'b1,
                        (param_ff == fsp_pkg::P_MINOR) ? fsp_pkg::VER_MINOR :
                        (param_ff == fsp_pkg::P_MAJOR) ? fsp_pkg::VER_MAJOR :
                        fsp_pkg::VER_OTHER, fsp_pkg::MC_NONE, 17'd0, 1'b0, 1'b0);
                     cnt          = cnt + 3'd1;
                  end
                  fsp_pkg::C_SIGN: begin
                     job.ent[cnt] = fsp_pkg::mk_ent(1'b1, cfg.sig_high, fsp_pkg::MC_NONE,
                                                    17'd0, 1'b0, 1'b0);
                     cnt          = cnt + 3'd1;
                     job.ent[cnt] = fsp_pkg::mk_ent(1'b1, cfg.sig_mid, fsp_pkg::MC_NONE,
                                                    17'd0, 1'b0, 1'b0);
                     cnt          = cnt + 3'd1;
                     job.ent[cnt] = fsp_pkg::mk_ent(1'b1, cfg.sig_low, fsp_pkg::MC_NONE,
                                                    17'd0, 1'b0, 1'b0);
                     cnt          = cnt + 3'd1;
                  end
                  fsp_pkg::C_UNIV: begin
                     job.ent[cnt] = fsp_pkg::mk_ent(1'b1, 8'h00, fsp_pkg::MC_NONE,
                                                    17'd0, 1'b0, 1'b0);
                     cnt          = cnt + 3'd1;
                  end
                  fsp_pkg::C_LEAVE: begin
                     job.ent[cnt] = fsp_pkg::mk_ent(1'b0, 8'h00, fsp_pkg::MC_LEAVE,
                                                    cfg.boot_area_end[16:0], 1'b0, 1'b0);
                     cnt          = cnt + 3'd1;
                  end
                  fsp_pkg::C_PROG: begin
                     if ({1'b0, off_ff} < cfg.flash_limit &&
                         {1'b0, off_ff} >= cfg.boot_area_end) begin
                        phase_in = PH_WRITE;
                        if (aligned_ff) begin
                           wp_in        = '0;
                           job.ent[cnt] = fsp_pkg::mk_ent(1'b0, 8'h00, fsp_pkg::MC_ERASE,
                                                          off_ff, 1'b0, 1'b0);
                        end else begin
                           wp_in        = WPW'(1);
                           job.widx     = '0;
                           job.mask     = word_mask('0, pb);
                           job.ent[cnt] = fsp_pkg::mk_ent(1'b0, 8'h00, fsp_pkg::MC_WRITE,
                                                          off_ff, 1'b0, 1'b1);
                        end
                        cnt = cnt + 3'd1;
                     end
                  end
                  fsp_pkg::C_READ: begin
                     phase_in     = PH_READ;
                     ac_in        = tl_ff;
                     job.ent[cnt] = fsp_pkg::mk_ent(1'b0, 8'h00, fsp_pkg::MC_READ,
                                                    off_ff, 1'b0, 1'b0);
                     cnt          = cnt + 3'd1;
                  end
                  default: begin
                  end
               endcase
               if (!fail_in && phase_in == PH_CMD) begin
                  job.ent[cnt] = fsp_pkg::mk_ent(1'b1, fsp_pkg::B_OK, fsp_pkg::MC_NONE,
                                                 17'd0, 1'b0, 1'b0);
                  cnt          = cnt + 3'd1;
               end
            end
            default: begin
            end
         endcase
      end else if (phase_ff == PH_WRITE) begin
         if (17'(wp_ff) < words) begin
            job.widx     = fsp_pkg::WIDX_W'(wp_ff);
            job.mask     = word_mask(wp_ff, pb);
            job.ent[cnt] = fsp_pkg::mk_ent(1'b0, 8'h00, fsp_pkg::MC_WRITE,
                              off_ff + 17'({wp_ff, 2'b00}), 1'b0, 1'b1);
            cnt          = cnt + 3'd1;
            wp_in        = wp_ff + WPW'(1);
         end else begin
            phase_in = fail_ff ? PH_HUNT : PH_CMD;
            if (!fail_ff) begin
               job.ent[cnt] = fsp_pkg::mk_ent(1'b1, fsp_pkg::B_OK, fsp_pkg::MC_NONE,
                                              17'd0, 1'b0, 1'b0);
               cnt          = cnt + 3'd1;
            end
         end
      end else if (phase_ff == PH_READ) begin
         job.ent[cnt] = fsp_pkg::mk_ent(1'b1, req_mem_data, fsp_pkg::MC_NONE,
                                        17'd0, 1'b0, 1'b0);
         cnt          = cnt + 3'd1;
         ac_in        = ac_dec;
         if (ac_dec == 16'd0) begin
            phase_in = fail_ff ? PH_HUNT : PH_CMD;
            if (!fail_ff) begin
               job.ent[cnt] = fsp_pkg::mk_ent(1'b1, fsp_pkg::B_OK, fsp_pkg::MC_NONE,
                                              17'd0, 1'b0, 1'b0);
               cnt          = cnt + 3'd1;
            end
         end else begin
            job.ent[cnt] = fsp_pkg::mk_ent(1'b0, 8'h00, fsp_pkg::MC_READ,
                              off_ff + {1'b0, rd_idx}, 1'b0, 1'b0);
            cnt          = cnt + 3'd1;
         end
      end

      job.cnt = cnt;
      job.inv = inv_in;
      if (!fire) begin
         buf_wr.en = 1'b0;
      end
   end

   assign q_job  = job;
   assign q_push = fire && (cnt != 3'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         prev_ff  <= 8'h00;
         cmd_ff   <= 8'h00;
         off_ff   <= 17'd0;
         ac_ff    <= 16'd0;
         tl_ff    <= 16'd0;
         param_ff <= 8'h00;
         fail_ff  <= 1'b0;
         sr_ff    <= 3'd0;
         inv_ff   <= 1'b0;
         wp_ff    <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         prev_ff  <= prev_in;
         cmd_ff   <= cmd_in;
         off_ff   <= off_in;
         ac_ff    <= ac_in;
         tl_ff    <= tl_in;
         param_ff <= param_in;
         fail_ff  <= fail_in;
         sr_ff    <= sr_in;
         inv_ff   <= inv_in;
         wp_ff    <= wp_in;
      end
   end

   // erase page alignment of the byte offset, two stages behind it
   always_ff @(posedge clock) begin
      quo_ff     <= 17'(prod >> SH);
      aligned_ff <= (back_prod == 32'(off_ff));
   end

endmodule
